// ----- rtl/ppvc_pkg.sv -----
package ppvc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HEAD_BITS = 14;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_STORED = 2'd2;
  localparam logic [1:0] STAT_FULL   = 2'd3;

  localparam logic [2:0] CFG_FIXED_LA    = 3'd0;
  localparam logic [2:0] CFG_LA_FLOOR    = 3'd1;
  localparam logic [2:0] CFG_LA_CEILING  = 3'd2;
  localparam logic [2:0] CFG_SPD_CEILING = 3'd3;
  localparam logic [2:0] CFG_SPD_FLOOR   = 3'd4;
  localparam logic [2:0] CFG_TURN_LIMIT  = 3'd5;
  localparam logic [2:0] CFG_SLOWDOWN    = 3'd6;
  localparam logic [2:0] CFG_SCALED_ON   = 3'd7;

  localparam logic [56:0] CURV_THRESH = 57'((64'd1 << (2 * FRAC_BITS)) / 1000);

  typedef struct packed {
    logic [1:0]         func;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] robot_x;
    logic signed [23:0] robot_y;
    logic signed [15:0] heading_cos;
    logic signed [15:0] heading_sin;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [22:0]        linear_cmd;
    logic signed [23:0] angular_cmd;
    logic signed [23:0] carrot_x;
    logic signed [23:0] carrot_y;
  } out_item_t;

  typedef struct packed {
    logic [22:0] fixed_lookahead;
    logic [22:0] lookahead_floor;
    logic [22:0] lookahead_ceiling;
    logic [22:0] speed_ceiling;
    logic [22:0] speed_floor;
    logic [22:0] turn_rate_limit;
    logic [22:0] slowdown_distance;
    logic        scaled_lookahead_on;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] robot_x;
    logic signed [23:0] robot_y;
    logic signed [15:0] heading_cos;
    logic signed [15:0] heading_sin;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
  } job_t;

endpackage

// ----- rtl/pure_pursuit_velocity_command.sv -----
// channel  ports                                      transfer
// input    start, busy, in_data                       start && !busy
// result   out_valid, out_data                        out_valid (one cycle, no stall)
// config   cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// Clear and append items give their result in the cycle after the back end takes them.
// A compute item passes from the queue to its result through the point scan, which reads
// the stored points one at a time, and the bit-serial square root and divider units; the
// back end takes no new item from the queue until that result is out.
// rst_n is synchronous; the stored path is empty after reset, no clearing pass.
// busy rises when the two-entry queue is full, and after a clear until it drains.
module pure_pursuit_velocity_command #(
  parameter int PATH_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ppvc_pkg::in_item_t  in_data,
  output logic                out_valid,
  output ppvc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [22:0]         cfg_data
);

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int LW = $clog2(PATH_DEPTH + 1);

  ppvc_pkg::cfg_regs_t cfg_r;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [47:0]         ram_wdata, ram_rdata;
  logic                q_valid, q_pop, back_idle;
  ppvc_pkg::job_t      q_job;
  logic [LW-1:0]       q_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fixed_lookahead     <= 23'd39322;
      cfg_r.lookahead_floor     <= 23'd19661;
      cfg_r.lookahead_ceiling   <= 23'd65536;
      cfg_r.speed_ceiling       <= 23'd19661;
      cfg_r.speed_floor         <= 23'd3277;
      cfg_r.turn_rate_limit     <= 23'd52429;
      cfg_r.slowdown_distance   <= 23'd52429;
      cfg_r.scaled_lookahead_on <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppvc_pkg::CFG_FIXED_LA:    cfg_r.fixed_lookahead     <= cfg_data;
        ppvc_pkg::CFG_LA_FLOOR:    cfg_r.lookahead_floor     <= cfg_data;
        ppvc_pkg::CFG_LA_CEILING:  cfg_r.lookahead_ceiling   <= cfg_data;
        ppvc_pkg::CFG_SPD_CEILING: cfg_r.speed_ceiling       <= cfg_data;
        ppvc_pkg::CFG_SPD_FLOOR:   cfg_r.speed_floor         <= cfg_data;
        ppvc_pkg::CFG_TURN_LIMIT:  cfg_r.turn_rate_limit     <= cfg_data;
        ppvc_pkg::CFG_SLOWDOWN:    cfg_r.slowdown_distance   <= cfg_data;
        ppvc_pkg::CFG_SCALED_ON:   cfg_r.scaled_lookahead_on <= cfg_data[0];
      endcase
    end
  end

  ppvc_ram #(.WIDTH(48), .DEPTH(PATH_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  ppvc_front #(.PATH_DEPTH(PATH_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_len     (q_len),
    .q_pop     (q_pop),
    .back_idle (back_idle)
  );

  ppvc_back #(.PATH_DEPTH(PATH_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_len     (q_len),
    .q_pop     (q_pop),
    .back_idle (back_idle),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/ppvc_ram.sv -----
module ppvc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/ppvc_front.sv -----
module ppvc_front #(
  parameter int PATH_DEPTH = 256,
  localparam int AW = $clog2(PATH_DEPTH),
  localparam int LW = $clog2(PATH_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ppvc_pkg::in_item_t in_data,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [47:0]       ram_wdata,
  output logic              q_valid,
  output ppvc_pkg::job_t    q_job,
  output logic [LW-1:0]     q_len,
  input  logic              q_pop,
  input  logic              back_idle
);

  ppvc_pkg::job_t job_r [2];
  logic [LW-1:0]  qlen_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r, count_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic           hold_r, hold_nxt;
  logic           accept, full;
  ppvc_pkg::job_t job_new;

  assign full   = (len_r == LW'(PATH_DEPTH));
  assign busy   = (count_r == 2'd2) || hold_r;
  assign accept = start && !busy;

  always_comb begin
    job_new.robot_x     = in_data.robot_x;
    job_new.robot_y     = in_data.robot_y;
    job_new.heading_cos = in_data.heading_cos;
    job_new.heading_sin = in_data.heading_sin;
    job_new.vel_x       = in_data.vel_x;
    job_new.vel_y       = in_data.vel_y;
    len_nxt             = len_r;
    ram_we              = 1'b0;
    priority if (in_data.func == ppvc_pkg::FUNC_CLEAR) begin
      job_new.kind = ppvc_pkg::STAT_EMPTY;
      if (accept) len_nxt = '0;
    end else if (in_data.func == ppvc_pkg::FUNC_APPEND) begin
      job_new.kind = full ? ppvc_pkg::STAT_FULL : ppvc_pkg::STAT_STORED;
      if (accept && !full) begin
        len_nxt = len_r + LW'(1);
        ram_we  = 1'b1;
      end
    end else begin
      job_new.kind = ppvc_pkg::STAT_OK;
    end
  end

  assign ram_waddr = len_r[AW-1:0];
  assign ram_wdata = {in_data.point_x, in_data.point_y};

  always_comb begin
    count_nxt = count_r + {1'b0, accept} - {1'b0, q_pop};
    hold_nxt  = hold_r;
    if (accept && in_data.func == ppvc_pkg::FUNC_CLEAR) begin
      hold_nxt = 1'b1;
    end else if (count_r == 2'd0 && back_idle) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      len_r    <= '0;
      hold_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      len_r   <= len_nxt;
      hold_r  <= hold_nxt;
      if (accept) wr_ptr_r <= !wr_ptr_r;
      if (q_pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r[wr_ptr_r]  <= job_new;
      qlen_r[wr_ptr_r] <= len_r;
    end
  end

  assign q_valid = (count_r != 2'd0);
  assign q_job   = job_r[rd_ptr_r];
  assign q_len   = qlen_r[rd_ptr_r];

endmodule

// ----- rtl/ppvc_back.sv -----
module ppvc_back #(
  parameter int PATH_DEPTH = 256,
  localparam int AW = $clog2(PATH_DEPTH),
  localparam int LW = $clog2(PATH_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ppvc_pkg::cfg_regs_t cfg,
  input  logic                q_valid,
  input  ppvc_pkg::job_t      q_job,
  input  logic [LW-1:0]       q_len,
  output logic                q_pop,
  output logic                back_idle,
  output logic [AW-1:0]       ram_raddr,
  input  logic [47:0]         ram_rdata,
  output logic                out_valid,
  output ppvc_pkg::out_item_t out_data
);

  localparam int F     = ppvc_pkg::FRAC_BITS;
  localparam int NUM_W = 29 + 2 * F;

  localparam logic [4:0] S_IDLE = 5'd0,  S_VEL = 5'd1,   S_VSQ = 5'd2,   S_SQRT = 5'd3;
  localparam logic [4:0] S_LA = 5'd4,    S_LA2 = 5'd5,   S_LA3 = 5'd6,   S_SCAN_RD = 5'd7;
  localparam logic [4:0] S_SCAN_WT = 5'd8, S_SCAN_CMP = 5'd9, S_DSQ = 5'd10, S_ROT1 = 5'd11;
  localparam logic [4:0] S_ROT2 = 5'd12, S_ROT3 = 5'd13, S_CURV1 = 5'd14, S_CURV2 = 5'd15;
  localparam logic [4:0] S_DIV = 5'd16,  S_CURV3 = 5'd17, S_SLOW1 = 5'd18, S_SLOW2 = 5'd19;
  localparam logic [4:0] S_SLOW3 = 5'd20, S_CF1 = 5'd21, S_CF2 = 5'd22,  S_ANG1 = 5'd23;
  localparam logic [4:0] S_ANG2 = 5'd24;

  function automatic logic [22:0] clamp23(input logic [26:0] v, input logic [22:0] lo,
                                          input logic [22:0] hi);
    if (v < 27'(lo)) return lo;
    else if (27'(hi) < v) return hi;
    else return v[22:0];
  endfunction

  logic [4:0]          state_r, ret_r;
  ppvc_pkg::job_t      job_r;
  logic [LW-1:0]       len_r;
  logic [22:0]         la_r;
  logic [45:0]         la2_r;
  logic [AW-1:0]       idx_r;
  logic                first_r;
  logic signed [23:0]  px_r, py_r, cx_r, cy_r;
  logic [50:0]         goal_d2_r;
  logic signed [57:0]  p0_r, p1_r;
  logic signed [28:0]  ma0, mb0, ma1, mb1;
  logic [51:0]         sq_op_r;
  logic [27:0]         sq_rem_r;
  logic [25:0]         sq_root_r;
  logic [5:0]          cnt_r;
  logic [NUM_W-1:0]    dv_num_r;
  logic [57:0]         dv_rem_r;
  logic [56:0]         dv_den_r;
  logic [23:0]         dv_q_r;
  logic signed [27:0]  lx_r, ly_r;
  logic signed [23:0]  k_r;
  logic [22:0]         lin_r, lin2_r;
  logic                out_valid_r;
  ppvc_pkg::out_item_t out_data_r;

  logic [27:0]         sq_cur, sq_trial;
  logic                sq_ge;
  logic [57:0]         dv_cur;
  logic                dv_ge;
  logic signed [23:0]  ram_px, ram_py;
  logic signed [24:0]  dx_c, dy_c, sdx, sdy;
  logic [50:0]         scan_d2;
  logic [56:0]         curv_d2;
  logic signed [42:0]  rot_sum, rot_dif;
  logic [27:0]         sp3, ly_abs;
  logic [23:0]         k_abs;
  logic signed [41:0]  ang_w, lim_w;

  assign ram_px   = ram_rdata[47:24];
  assign ram_py   = ram_rdata[23:0];
  assign sdx      = 25'(ram_px) - 25'(job_r.robot_x);
  assign sdy      = 25'(ram_py) - 25'(job_r.robot_y);
  assign dx_c     = 25'(cx_r) - 25'(job_r.robot_x);
  assign dy_c     = 25'(cy_r) - 25'(job_r.robot_y);
  assign scan_d2  = 51'(p0_r[49:0]) + 51'(p1_r[49:0]);
  assign curv_d2  = 57'(p0_r[55:0]) + 57'(p1_r[55:0]);
  assign rot_sum  = 43'(p0_r) + 43'(p1_r);
  assign rot_dif  = 43'(p0_r) - 43'(p1_r);
  assign sp3      = 28'(sq_root_r) + 28'({sq_root_r, 1'b0});
  assign ly_abs   = ly_r[27] ? 28'(-ly_r) : 28'(ly_r);
  assign k_abs    = k_r[23] ? 24'(-k_r) : 24'(k_r);
  assign ang_w    = 42'(p0_r >>> F);
  assign lim_w    = 42'($signed({1'b0, cfg.turn_rate_limit}));

  assign sq_cur   = {sq_rem_r[25:0], sq_op_r[51:50]};
  assign sq_trial = {sq_root_r, 2'b01};
  assign sq_ge    = (sq_cur >= sq_trial);
  assign dv_cur   = {dv_rem_r[56:0], dv_num_r[NUM_W-1]};
  assign dv_ge    = (dv_cur >= {1'b0, dv_den_r});

  assign ram_raddr = idx_r;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign back_idle = (state_r == S_IDLE);

  always_comb begin
    ma0 = '0;
    mb0 = '0;
    ma1 = '0;
    mb1 = '0;
    unique case (state_r)
      S_VEL: begin
        ma0 = 29'(job_r.vel_x); mb0 = 29'(job_r.vel_x);
        ma1 = 29'(job_r.vel_y); mb1 = 29'(job_r.vel_y);
      end
      S_LA2: begin
        ma0 = 29'(la_r); mb0 = 29'(la_r);
      end
      S_SCAN_WT: begin
        ma0 = 29'(sdx); mb0 = 29'(sdx);
        ma1 = 29'(sdy); mb1 = 29'(sdy);
      end
      S_ROT1: begin
        ma0 = 29'(job_r.heading_cos); mb0 = 29'(dx_c);
        ma1 = 29'(job_r.heading_sin); mb1 = 29'(dy_c);
      end
      S_ROT2: begin
        ma0 = 29'(job_r.heading_cos); mb0 = 29'(dy_c);
        ma1 = 29'(job_r.heading_sin); mb1 = 29'(dx_c);
      end
      S_CURV1: begin
        ma0 = 29'(lx_r); mb0 = 29'(lx_r);
        ma1 = 29'(ly_r); mb1 = 29'(ly_r);
      end
      S_SLOW1: begin
        ma0 = 29'(sq_root_r); mb0 = 29'(cfg.speed_ceiling);
      end
      S_ANG1: begin
        ma0 = 29'(k_r); mb0 = 29'(lin2_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p0_r <= ma0 * mb0;
    p1_r <= ma1 * mb1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            job_r <= q_job;
            len_r <= q_len;
            if (q_job.kind != ppvc_pkg::STAT_OK) begin
              out_data_r  <= '{status: q_job.kind, default: '0};
              out_valid_r <= 1'b1;
            end else if (q_len == '0) begin
              out_data_r  <= '{status: ppvc_pkg::STAT_EMPTY, default: '0};
              out_valid_r <= 1'b1;
            end else begin
              state_r <= S_VEL;
            end
          end
        end
        S_VEL: state_r <= S_VSQ;
        S_VSQ: begin
          sq_op_r   <= 52'(p0_r[47:0]) + 52'(p1_r[47:0]);
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          cnt_r     <= 6'd26;
          ret_r     <= S_LA;
          state_r   <= S_SQRT;
        end
        S_SQRT: begin
          sq_rem_r  <= sq_ge ? sq_cur - sq_trial : sq_cur;
          sq_root_r <= {sq_root_r[24:0], sq_ge};
          sq_op_r   <= {sq_op_r[49:0], 2'b00};
          cnt_r     <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) state_r <= ret_r;
        end
        S_LA: begin
          la_r <= cfg.scaled_lookahead_on ?
                  clamp23(sp3[27:1], cfg.lookahead_floor, cfg.lookahead_ceiling) :
                  cfg.fixed_lookahead;
          state_r <= S_LA2;
        end
        S_LA2: state_r <= S_LA3;
        S_LA3: begin
          la2_r   <= p0_r[45:0];
          idx_r   <= AW'(len_r - LW'(1));
          first_r <= 1'b1;
          state_r <= S_SCAN_RD;
        end
        S_SCAN_RD: state_r <= S_SCAN_WT;
        S_SCAN_WT: begin
          px_r    <= ram_px;
          py_r    <= ram_py;
          state_r <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          first_r <= 1'b0;
          if (first_r) begin
            goal_d2_r <= scan_d2;
          end
          if (first_r || scan_d2 > 51'(la2_r)) begin
            cx_r <= px_r;
            cy_r <= py_r;
          end
          if (scan_d2 > 51'(la2_r) && idx_r != '0) begin
            idx_r   <= idx_r - AW'(1);
            state_r <= S_SCAN_RD;
          end else begin
            state_r <= S_DSQ;
          end
        end
        S_DSQ: begin
          sq_op_r   <= 52'(goal_d2_r);
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          cnt_r     <= 6'd26;
          ret_r     <= S_ROT1;
          state_r   <= S_SQRT;
        end
        S_ROT1: state_r <= S_ROT2;
        S_ROT2: begin
          lx_r    <= 28'(rot_sum >>> ppvc_pkg::HEAD_BITS);
          state_r <= S_ROT3;
        end
        S_ROT3: begin
          ly_r    <= 28'(rot_dif >>> ppvc_pkg::HEAD_BITS);
          state_r <= S_CURV1;
        end
        S_CURV1: state_r <= S_CURV2;
        S_CURV2: begin
          if (curv_d2 > ppvc_pkg::CURV_THRESH) begin
            dv_num_r <= {ly_abs[27:0], 1'b0, (2 * F)'(0)};
            dv_den_r <= curv_d2;
            dv_rem_r <= '0;
            dv_q_r   <= '0;
            cnt_r    <= 6'(NUM_W);
            ret_r    <= S_CURV3;
            state_r  <= S_DIV;
          end else begin
            k_r     <= '0;
            state_r <= S_SLOW1;
          end
        end
        S_DIV: begin
          dv_rem_r <= dv_ge ? dv_cur - {1'b0, dv_den_r} : dv_cur;
          dv_q_r   <= {dv_q_r[22:0], dv_ge};
          dv_num_r <= {dv_num_r[NUM_W-2:0], 1'b0};
          cnt_r    <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) state_r <= ret_r;
        end
        S_CURV3: begin
          k_r     <= ly_r[27] ? -$signed(dv_q_r) : $signed(dv_q_r);
          state_r <= S_SLOW1;
        end
        S_SLOW1: begin
          if (sq_root_r < 26'(cfg.slowdown_distance)) begin
            state_r <= S_SLOW2;
          end else begin
            lin_r   <= cfg.speed_ceiling;
            state_r <= S_CF1;
          end
        end
        S_SLOW2: begin
          dv_num_r <= NUM_W'(p0_r[48:0]);
          dv_den_r <= 57'(cfg.slowdown_distance);
          dv_rem_r <= '0;
          dv_q_r   <= '0;
          cnt_r    <= 6'(NUM_W);
          ret_r    <= S_SLOW3;
          state_r  <= S_DIV;
        end
        S_SLOW3: begin
          lin_r   <= (dv_q_r > 24'(cfg.speed_floor)) ? dv_q_r[22:0] : cfg.speed_floor;
          state_r <= S_CF1;
        end
        S_CF1: begin
          dv_num_r <= NUM_W'({lin_r, F'(0)});
          dv_den_r <= 57'({1'b1, F'(0)}) + 57'({k_abs, 1'b0});
          dv_rem_r <= '0;
          dv_q_r   <= '0;
          cnt_r    <= 6'(NUM_W);
          ret_r    <= S_CF2;
          state_r  <= S_DIV;
        end
        S_CF2: begin
          lin2_r  <= dv_q_r[22:0];
          state_r <= S_ANG1;
        end
        S_ANG1: state_r <= S_ANG2;
        S_ANG2: begin
          out_data_r.status     <= ppvc_pkg::STAT_OK;
          out_data_r.linear_cmd <= clamp23(27'(lin2_r), cfg.speed_floor, cfg.speed_ceiling);
          if (ang_w < -lim_w) out_data_r.angular_cmd <= 24'(-lim_w);
          else if (ang_w > lim_w) out_data_r.angular_cmd <= 24'(lim_w);
          else out_data_r.angular_cmd <= 24'(ang_w);
          out_data_r.carrot_x <= cx_r;
          out_data_r.carrot_y <= cy_r;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("pop outside idle");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN_RD |-> LW'(idx_r) < len_r) else $error("scan index beyond path");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_IDLE || $past(state_r) == S_ANG2)
    else $error("result from wrong state");

endmodule
